// ===== rtl/i2cram_pkg.sv =====
package i2cram_pkg;

  // Width of the half-bit phase counter.
  localparam int unsigned TickW = 16;
  // Compare width: wide enough for the counter plus one and for a phase length.
  localparam int unsigned CmpW = ((TickW > 16) ? TickW : 16) + 1;

  // Depth of the request queue between front and sequencer.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PHASE     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACK_LIMIT = 2'd2;

  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [15:0] PhaseTicksReset = 16'd5;
  localparam logic [7:0]  AckLimitReset   = 8'd200;
  localparam logic [7:0]  MsbMask         = 8'h80;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_item_t;

  typedef struct packed {
    logic                en;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

// ===== rtl/i2cram_req_if.sv =====
interface i2cram_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, op, reg_addr, write_data, sda_in, input ready);
  modport sink (input valid, op, reg_addr, write_data, sda_in, output ready);
endinterface

// ===== rtl/i2cram_rsp_if.sv =====
interface i2cram_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       nack_seen;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                  nack_seen, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                nack_seen, output ready);
endinterface

// ===== rtl/i2cram_front.sv =====
module i2cram_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  i2cram_req_if.sink             req,
  output logic                   q_valid_o,
  output i2cram_pkg::tick_item_t q_item_o,
  input  logic                   q_pop_i
);
  import i2cram_pkg::*;

  tick_item_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;
  tick_item_t       item;

  // Op code three means nothing, like op zero.
  always_comb begin
    item.reg_addr   = req.reg_addr;
    item.write_data = req.write_data;
    item.sda_in     = req.sda_in;
    case (req.op)
      OP_WRITE: item.cmd = CMD_WRITE;
      OP_READ:  item.cmd = CMD_READ;
      default:  item.cmd = CMD_NONE;
    endcase
  end

  assign req.ready = (cnt_q != QCntW'(QDepth));
  assign push      = req.valid && req.ready;
  assign pop       = q_pop_i && (cnt_q != '0);
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ===== rtl/i2cram_seq.sv =====
module i2cram_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2cram_pkg::cfg_wr_t    cfg_i,
  input  logic                   q_valid_i,
  input  i2cram_pkg::tick_item_t q_item_i,
  output logic                   q_pop_o,
  i2cram_rsp_if.source           rsp
);
  import i2cram_pkg::*;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_ST_A    = 5'd1;
  localparam logic [4:0] PH_ST_B    = 5'd2;
  localparam logic [4:0] PH_ST_C    = 5'd3;
  localparam logic [4:0] PH_TX_LO   = 5'd4;
  localparam logic [4:0] PH_TX_HI   = 5'd5;
  localparam logic [4:0] PH_AK_LO   = 5'd6;
  localparam logic [4:0] PH_AK_HI   = 5'd7;
  localparam logic [4:0] PH_AK_POLL = 5'd8;
  localparam logic [4:0] PH_AK_END  = 5'd9;
  localparam logic [4:0] PH_RS_LO   = 5'd10;
  localparam logic [4:0] PH_RX_LO   = 5'd11;
  localparam logic [4:0] PH_RX_HI   = 5'd12;
  localparam logic [4:0] PH_NK_LO   = 5'd13;
  localparam logic [4:0] PH_NK_HI   = 5'd14;
  localparam logic [4:0] PH_SP_A    = 5'd15;
  localparam logic [4:0] PH_SP_B    = 5'd16;
  localparam logic [4:0] PH_SP_C    = 5'd17;

  // Configuration registers.
  logic [6:0]  dev_addr_q;
  logic [15:0] phase_ticks_q;
  logic [7:0]  ack_limit_q;

  // Sequencer state.
  logic [4:0]       phase_q, phase_d;
  logic [3:0]       bit_idx_q, bit_idx_d;
  logic [7:0]       shift_q, shift_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [7:0]       ackw_q, ackw_d;
  logic             is_wr_q, is_wr_d;
  logic [7:0]       reg_q, reg_d;
  logic [7:0]       data_q, data_d;
  logic [7:0]       rx_q, rx_d;
  logic             nack_q, nack_d;
  logic [1:0]       slot_q, slot_d;

  // Result register.
  logic       out_valid_q;
  logic       scl_q, sda_q, busy_q, done_q;
  logic       scl_d, sda_d, done_d;

  logic             step;
  logic             pe;
  logic [15:0]      plen;
  logic [CmpW-1:0]  tick_plus;
  logic [TickW-1:0] tick_pe;
  logic [3:0]       bit_inc;
  logic [7:0]       rx_shift;

  function automatic logic [7:0] tx_byte(input logic [1:0] slot, input logic is_wr,
                                         input logic [7:0] rg, input logic [7:0] dat,
                                         input logic [6:0] dev);
    logic [7:0] b;
    if (slot == 2'd0) begin
      b = {dev, 1'b0};
    end else if (slot == 2'd1) begin
      b = rg;
    end else if (is_wr) begin
      b = dat;
    end else begin
      b = {dev, 1'b1};
    end
    return b;
  endfunction

  // A new tick is taken whenever the result register is free or being drained.
  assign step    = q_valid_i && (!out_valid_q || rsp.ready);
  assign q_pop_o = step;

  // Phase timer: a zero length counts as one tick, and a full counter ends the phase.
  assign plen      = (phase_ticks_q == '0) ? 16'd1 : phase_ticks_q;
  assign tick_plus = CmpW'(tick_q) + CmpW'(1);
  assign pe        = (tick_plus >= CmpW'(plen)) || (tick_q == '1);
  assign tick_pe   = pe ? '0 : tick_plus[TickW-1:0];
  assign bit_inc   = bit_idx_q + 4'd1;
  assign rx_shift  = {shift_q[6:0], q_item_i.sda_in};

  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    tick_d    = tick_q;
    ackw_d    = ackw_q;
    is_wr_d   = is_wr_q;
    reg_d     = reg_q;
    data_d    = data_q;
    rx_d      = rx_q;
    nack_d    = nack_q;
    slot_d    = slot_q;
    done_d    = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (q_item_i.cmd == CMD_WRITE || q_item_i.cmd == CMD_READ) begin
          is_wr_d   = (q_item_i.cmd == CMD_WRITE);
          reg_d     = q_item_i.reg_addr;
          data_d    = q_item_i.write_data;
          nack_d    = 1'b0;
          slot_d    = 2'd0;
          tick_d    = '0;
          ackw_d    = '0;
          bit_idx_d = '0;
          phase_d   = PH_ST_A;
        end
      end
      PH_ST_A: begin
        tick_d = tick_pe;
        if (pe) phase_d = PH_ST_B;
      end
      PH_ST_B: begin
        tick_d = tick_pe;
        if (pe) phase_d = PH_ST_C;
      end
      PH_ST_C: begin
        tick_d = tick_pe;
        if (pe) begin
          shift_d   = tx_byte(slot_q, is_wr_q, reg_q, data_q, dev_addr_q);
          bit_idx_d = '0;
          phase_d   = PH_TX_LO;
        end
      end
      PH_TX_LO: begin
        tick_d = tick_pe;
        if (pe) phase_d = PH_TX_HI;
      end
      PH_TX_HI: begin
        tick_d = tick_pe;
        if (pe) begin
          shift_d   = {shift_q[6:0], 1'b0};
          bit_idx_d = bit_inc;
          phase_d   = (bit_inc >= 4'd8) ? PH_AK_LO : PH_TX_LO;
        end
      end
      PH_AK_LO: begin
        tick_d = tick_pe;
        if (pe) phase_d = PH_AK_HI;
      end
      PH_AK_HI: begin
        tick_d = tick_pe;
        if (pe) begin
          ackw_d  = '0;
          phase_d = PH_AK_POLL;
        end
      end
      PH_AK_POLL: begin
        if (!q_item_i.sda_in) begin
          phase_d = PH_AK_END;
        end else if (ackw_q >= ack_limit_q) begin
          nack_d  = 1'b1;
          phase_d = PH_AK_END;
        end else begin
          ackw_d = ackw_q + 8'd1;
        end
        tick_d = '0;
      end
      PH_AK_END: begin
        tick_d = tick_pe;
        if (pe) begin
          if (slot_q == 2'd0) begin
            slot_d    = 2'd1;
            shift_d   = tx_byte(2'd1, is_wr_q, reg_q, data_q, dev_addr_q);
            bit_idx_d = '0;
            phase_d   = PH_TX_LO;
          end else if (slot_q == 2'd1) begin
            slot_d = 2'd2;
            if (is_wr_q) begin
              shift_d   = tx_byte(2'd2, is_wr_q, reg_q, data_q, dev_addr_q);
              bit_idx_d = '0;
              phase_d   = PH_TX_LO;
            end else begin
              phase_d = PH_RS_LO;
            end
          end else if (is_wr_q) begin
            phase_d = PH_SP_A;
          end else begin
            shift_d   = '0;
            bit_idx_d = '0;
            phase_d   = PH_RX_LO;
          end
        end
      end
      PH_RS_LO: begin
        tick_d = tick_pe;
        if (pe) phase_d = PH_ST_A;
      end
      PH_RX_LO: begin
        tick_d = tick_pe;
        if (pe) phase_d = PH_RX_HI;
      end
      PH_RX_HI: begin
        tick_d = tick_pe;
        if (pe) begin
          shift_d   = rx_shift;
          bit_idx_d = bit_inc;
          if (bit_inc >= 4'd8) begin
            rx_d    = rx_shift;
            phase_d = PH_NK_LO;
          end else begin
            phase_d = PH_RX_LO;
          end
        end
      end
      PH_NK_LO: begin
        tick_d = tick_pe;
        if (pe) phase_d = PH_NK_HI;
      end
      PH_NK_HI: begin
        tick_d = tick_pe;
        if (pe) phase_d = PH_SP_A;
      end
      PH_SP_A: begin
        tick_d = tick_pe;
        if (pe) phase_d = PH_SP_B;
      end
      PH_SP_B: begin
        tick_d = tick_pe;
        if (pe) phase_d = PH_SP_C;
      end
      PH_SP_C: begin
        tick_d = tick_pe;
        if (pe) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  // Line levels follow the phase that the tick leaves the sequencer in.
  always_comb begin
    scl_d = 1'b1;
    sda_d = 1'b1;
    case (phase_d)
      PH_ST_B: sda_d = 1'b0;
      PH_ST_C: begin
        scl_d = 1'b0;
        sda_d = 1'b0;
      end
      PH_TX_LO: begin
        scl_d = 1'b0;
        sda_d = |(shift_d & MsbMask);
      end
      PH_TX_HI: sda_d = |(shift_d & MsbMask);
      PH_AK_LO, PH_RS_LO, PH_RX_LO, PH_NK_LO: scl_d = 1'b0;
      PH_SP_A: begin
        scl_d = 1'b0;
        sda_d = 1'b0;
      end
      PH_SP_B: sda_d = 1'b0;
      default: begin
        scl_d = 1'b1;
        sda_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= '0;
      phase_ticks_q <= PhaseTicksReset;
      ack_limit_q   <= AckLimitReset;
    end else if (cfg_i.en) begin
      case (cfg_i.idx)
        CFG_DEV_ADDR:  dev_addr_q    <= cfg_i.data[6:0];
        CFG_PHASE:     phase_ticks_q <= cfg_i.data[15:0];
        CFG_ACK_LIMIT: ack_limit_q   <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_idx_q <= '0;
      shift_q   <= '0;
      tick_q    <= '0;
      ackw_q    <= '0;
      is_wr_q   <= 1'b0;
      reg_q     <= '0;
      data_q    <= '0;
      rx_q      <= '0;
      nack_q    <= 1'b0;
      slot_q    <= '0;
    end else if (step) begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      tick_q    <= tick_d;
      ackw_q    <= ackw_d;
      is_wr_q   <= is_wr_d;
      reg_q     <= reg_d;
      data_q    <= data_d;
      rx_q      <= rx_d;
      nack_q    <= nack_d;
      slot_q    <= slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      scl_q  <= scl_d;
      sda_q  <= sda_d;
      busy_q <= (phase_d != PH_IDLE);
      done_q <= done_d;
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.scl_out   = scl_q;
  assign rsp.sda_out   = sda_q;
  assign rsp.busy_res  = busy_q;
  assign rsp.done_res  = done_q;
  assign rsp.read_data = rx_q;
  assign rsp.nack_seen = nack_q;

endmodule

// ===== rtl/i2c_register_access_master_top.sv =====
// Tick-driven I2C master for single-register write and read transactions.
// Every request on the req channel is one bus tick: the sampled SDA level and
// an optional command (register write or register read). Every request yields
// exactly one response on the rsp channel: the SCL and SDA drive levels after
// that tick, busy and done flags, the last received byte and the sticky NACK
// flag. Commands that arrive while a transaction is running are ignored.
// Configuration (device address, ticks per half-bit phase, ack poll limit) is
// written through the cfg port; the user must write it only while the block is
// idle; the block itself does not enforce this. A front stage takes requests
// into a two-entry queue; the sequencer pops one request per cycle while the
// output register is free or being drained, and writes its response into that
// register. A request passes through the queue and then the output register
// before its response is valid on rsp. When the receiver stalls, the response
// holds and the queue absorbs up to two more requests before req.ready drops.
// Reset returns the sequencer to idle and loads the config reset values; the
// SCL and SDA drive registers are not reset.
module i2c_register_access_master_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [i2cram_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [i2cram_pkg::CfgDataW-1:0]    cfg_data_i,
  i2cram_req_if.sink                         req,
  i2cram_rsp_if.source                       rsp
);
  import i2cram_pkg::*;

  cfg_wr_t    cfg;
  logic       q_valid;
  logic       q_pop;
  tick_item_t q_item;

  assign cfg.en   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  i2cram_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  i2cram_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .rsp       (rsp)
  );

  // An accepted request is waiting in the queue on the next cycle.
  a_req_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> q_valid)
    else $error("accepted request missing from queue");

  // The sequencer only steps when a request is queued.
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("sequencer stepped on an empty queue");

  // Done marks the end of a transaction, so busy is already low with it.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.done_res) |-> !rsp.busy_res)
    else $error("done reported while busy");

endmodule
